[rtl/lspp_pkg.sv]
package lspp_pkg;

  localparam logic [7:0] SYNC_BYTE   = 8'hFA;
  localparam logic [7:0] INDEX_BASE  = 8'hA0;
  localparam logic [7:0] INDEX_COUNT = 8'd90;
  localparam logic [6:0] LAST_INDEX  = 7'd89;
  localparam logic [8:0] TALLY_MAX   = 9'd511;

  // Position of the final (checksum) byte of a 22-byte packet
  localparam logic [4:0] LAST_POS = 5'd21;
  // Highest byte position that the collector stores
  localparam int         KEEP_LAST = 19;

  localparam int NUM_READ = 4;

  // Collected packet as seen by the decoder
  typedef struct packed {
    logic                     done;        // last byte of a packet is transferred now
    logic                     tail;        // next byte would complete a packet
    logic [7:0]               index_byte;
    logic [15:0]              speed_word;
    logic [NUM_READ-1:0][7:0] rd_lo;
    logic [NUM_READ-1:0][7:0] rd_hi;
  } pkt_t;

endpackage

[rtl/lspp_collect.sv]
module lspp_collect (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_accept,
  input  logic [7:0]       in_byte,
  output lspp_pkg::pkt_t   pkt
);

  logic       in_packet;
  logic [4:0] byte_count;
  logic [7:0] pkt_byte [1:lspp_pkg::KEEP_LAST];

  always_ff @(posedge clk) begin
    if (rst) begin
      in_packet  <= 1'b0;
      byte_count <= 5'd0;
    end else if (in_accept) begin
      if (!in_packet) begin
        if (in_byte == lspp_pkg::SYNC_BYTE) begin
          in_packet  <= 1'b1;
          byte_count <= 5'd1;
        end
      end else if (byte_count == lspp_pkg::LAST_POS) begin
        in_packet  <= 1'b0;
        byte_count <= 5'd0;
      end else begin
        byte_count <= byte_count + 5'd1;
      end
    end
  end

  // Keep only the header and reading bytes; checksum bytes are not used
  always_ff @(posedge clk) begin
    if (in_accept && in_packet && byte_count >= 5'd1
        && byte_count <= 5'(lspp_pkg::KEEP_LAST)) begin
      pkt_byte[byte_count] <= in_byte;
    end
  end

  always_comb begin
    pkt.tail       = in_packet && (byte_count == lspp_pkg::LAST_POS);
    pkt.done       = in_accept && pkt.tail;
    pkt.index_byte = pkt_byte[1];
    pkt.speed_word = {pkt_byte[3], pkt_byte[2]};
    for (int i = 0; i < lspp_pkg::NUM_READ; i++) begin
      pkt.rd_lo[i] = pkt_byte[4 + 4 * i];
      pkt.rd_hi[i] = pkt_byte[5 + 4 * i];
    end
  end

endmodule

[rtl/lspp_decode.sv]
module lspp_decode #(
  parameter int MAX_RANGE_MM = 4000,
  parameter int RANGE_BINS   = 256
) (
  input  logic           clk,
  input  logic           rst,
  input  lspp_pkg::pkt_t pkt,
  input  logic           m_tready,
  output logic           m_tvalid,
  output logic [55:0]    m_tdata,
  output logic           m_tuser,
  output logic           m_tlast,
  output logic           busy
);

  localparam int NR = lspp_pkg::NUM_READ;

  // Distances at or above SAT_DIST give a bin above 255
  localparam longint unsigned SAT_DIST =
    (256 * longint'(MAX_RANGE_MM) + longint'(RANGE_BINS) - 1) / longint'(RANGE_BINS);
  localparam longint unsigned XMAX =
    (SAT_DIST < longint'(MAX_RANGE_MM)) ? SAT_DIST : longint'(MAX_RANGE_MM);
  localparam int SHIFT = $clog2(XMAX * longint'(MAX_RANGE_MM));
  // Reciprocal of MAX_RANGE_MM scaled by RANGE_BINS, exact for distances below XMAX
  localparam longint unsigned MULT_L =
    ((longint'(1) << SHIFT) * longint'(RANGE_BINS) + longint'(MAX_RANGE_MM) - 1)
    / longint'(MAX_RANGE_MM);
  localparam int MULT_W = 25;
  localparam logic [MULT_W-1:0] MULT      = MULT_W'(MULT_L);
  localparam logic [31:0]       SAT_LIM   = 32'(SAT_DIST);
  localparam logic [13:0]       RANGE_LIM = 14'(MAX_RANGE_MM);

  logic [7:0]          idx_diff;
  logic                idx_good;
  logic                load;
  logic [6:0]          idx;
  logic [NR-1:0]       bad;
  logic [13:0]         dist_mm  [NR];
  logic [NR-1:0]       inr;
  logic [7:0]          bin      [NR];
  logic [14+MULT_W-1:0] prod    [NR];
  logic [2:0]          bad_cnt;
  logic [9:0]          tally_sum;
  logic [8:0]          tally_next;

  logic [8:0]  tally;
  logic [1:0]  slot;
  logic [6:0]  out_idx;
  logic [9:0]  out_speed;
  logic        out_done;
  logic [8:0]  out_count;
  logic [13:0] out_dist [NR];
  logic        out_bad  [NR];
  logic [7:0]  out_bin  [NR];
  logic        out_inr  [NR];

  always_comb begin
    idx_diff = pkt.index_byte - lspp_pkg::INDEX_BASE;
    idx_good = (pkt.index_byte >= lspp_pkg::INDEX_BASE)
               && (idx_diff < lspp_pkg::INDEX_COUNT);
    load     = pkt.done && idx_good;
    idx      = idx_diff[6:0];
    bad_cnt  = 3'd0;
    for (int i = 0; i < NR; i++) begin
      bad[i]     = pkt.rd_hi[i][7];
      dist_mm[i] = bad[i] ? 14'd0 : {pkt.rd_hi[i][5:0], pkt.rd_lo[i]};
      inr[i]     = !bad[i] && (dist_mm[i] < RANGE_LIM);
      prod[i]    = (14 + MULT_W)'(dist_mm[i]) * (14 + MULT_W)'(MULT);
      if (!inr[i]) begin
        bin[i] = 8'd0;
      end else if (32'(dist_mm[i]) >= SAT_LIM) begin
        bin[i] = 8'd255;
      end else begin
        bin[i] = 8'(prod[i] >> SHIFT);
      end
      bad_cnt = bad_cnt + 3'(bad[i]);
    end
    tally_sum  = {1'b0, tally} + 10'(bad_cnt);
    tally_next = (tally_sum > 10'(lspp_pkg::TALLY_MAX)) ? lspp_pkg::TALLY_MAX
                                                         : tally_sum[8:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      slot  <= 2'd0;
      tally <= 9'd0;
    end else begin
      if (load) begin
        busy  <= 1'b1;
        slot  <= 2'd0;
        tally <= (idx == lspp_pkg::LAST_INDEX) ? 9'd0 : tally_next;
      end else if (busy && m_tready) begin
        slot <= slot + 2'd1;
        if (slot == 2'd3) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_idx   <= idx;
      out_speed <= pkt.speed_word[15:6];
      out_done  <= (idx == lspp_pkg::LAST_INDEX);
      out_count <= tally_next;
      for (int i = 0; i < NR; i++) begin
        out_dist[i] <= dist_mm[i];
        out_bad[i]  <= bad[i];
        out_bin[i]  <= bin[i];
        out_inr[i]  <= inr[i];
      end
    end
  end

  assign m_tvalid = busy;
  assign m_tdata  = {4'b0, out_count, out_speed, out_inr[slot], out_bin[slot],
                     out_bad[slot], out_dist[slot], out_idx, slot};
  assign m_tuser  = out_done;
  assign m_tlast  = (slot == 2'd3);

  a_no_load_while_busy: assert property (@(posedge clk) disable iff (rst)
    !(load && busy))
    else $error("packet results loaded while previous results pending");

  a_load_starts_slot0: assert property (@(posedge clk) disable iff (rst)
    load |=> (busy && slot == 2'd0))
    else $error("result buffer not started at first reading");

  a_drain_ends: assert property (@(posedge clk) disable iff (rst)
    (busy && m_tready && slot == 2'd3) |=> !busy)
    else $error("result buffer still busy after fourth transfer");

  a_pass_clears_tally: assert property (@(posedge clk) disable iff (rst)
    (load && idx == lspp_pkg::LAST_INDEX) |=> (tally == 9'd0))
    else $error("error tally not cleared at end of pass");

endmodule

[rtl/lidar_scan_packet_parser_unit.sv]
// Channel   Dir  Handshake            Payload
// s_*       in   s_tvalid/s_tready    s_tdata: rx_byte
// m_*       out  m_tvalid/m_tready    m_tdata, m_tuser: pass_done, m_tlast: last_of_packet
//
// One byte is taken per cycle while s_tready is high. A good packet yields four results from a four-entry
// result buffer, one per cycle while m_tready is high, starting the cycle after its
// last byte. rst (synchronous) returns the parser to sync hunting and clears the tally.
// s_tready drops only on a packet's final byte while the previous packet's results
// are still in the buffer; m_tready low holds the current result.
module lidar_scan_packet_parser_unit #(
  parameter int MAX_RANGE_MM = 4000,
  parameter int RANGE_BINS   = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  // [8:0] angle, [22:9] distance_mm, [23] reading_invalid, [31:24] range_bin,
  // [32] in_range, [42:33] rotation_speed, [51:43] pass_error_count, [55:52] zero
  output logic [55:0] m_tdata,
  output logic        m_tuser,   // [0] pass_done
  output logic        m_tlast
);

  lspp_pkg::pkt_t pkt;
  logic           busy;
  logic           in_accept;

  // Stall the completing byte until the result buffer is free
  assign s_tready  = !(pkt.tail && busy);
  assign in_accept = s_tvalid && s_tready;

  lspp_collect u_collect (
    .clk       (clk),
    .rst       (rst),
    .in_accept (in_accept),
    .in_byte   (s_tdata),
    .pkt       (pkt)
  );

  lspp_decode #(
    .MAX_RANGE_MM (MAX_RANGE_MM),
    .RANGE_BINS   (RANGE_BINS)
  ) u_decode (
    .clk      (clk),
    .rst      (rst),
    .pkt      (pkt),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .busy     (busy)
  );

endmodule

[dv/lidar_scan_packet_parser_unit_tb.sv]
`timescale 1ns / 1ps

module lidar_scan_packet_parser_unit_tb;

  localparam int MAX_RANGE_MM = 4000;
  localparam int RANGE_BINS   = 256;
  localparam int FRAME_LEN    = 22;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 50000;

  typedef struct packed {
    logic [8:0]  angle;
    logic [13:0] distance_mm;
    logic        reading_invalid;
    logic [7:0]  range_bin;
    logic        in_range;
    logic [9:0]  rotation_speed;
    logic        pass_done;
    logic [8:0]  pass_error_count;
    logic        last_of_packet;
  } reading_t;

  // Tracks the byte framing and the pass tally; holds the readings still owed.
  class scan_scoreboard;
    logic        in_pkt;
    int unsigned nbytes;
    logic [7:0]  frame [FRAME_LEN];
    int unsigned tally;
    reading_t    readings_due [$];
    int unsigned errors, checked, good_pkts, dropped_pkts, passes, bytes_seen;

    function new();
      in_pkt = 1'b0;
      nbytes = 0;
      tally  = 0;
      foreach (frame[i]) frame[i] = '0;
    endfunction

    function int pending();
      return readings_due.size();
    endfunction

    function void note_byte(logic [7:0] b);
      int unsigned idx, spd, dist_mm, rbin;
      logic [7:0]  lo, hi;
      logic        bad, inr;
      reading_t    r;
      bytes_seen++;
      if (!in_pkt) begin
        if (b == lspp_pkg::SYNC_BYTE) begin
          in_pkt   = 1'b1;
          frame[0] = b;
          nbytes   = 1;
        end
        return;
      end
      frame[nbytes] = b;
      nbytes++;
      if (nbytes < FRAME_LEN) return;
      in_pkt = 1'b0;
      nbytes = 0;
      // drop packets whose index byte is outside the table
      if (frame[1] < lspp_pkg::INDEX_BASE
          || (frame[1] - lspp_pkg::INDEX_BASE) >= lspp_pkg::INDEX_COUNT) begin
        dropped_pkts++;
        return;
      end
      good_pkts++;
      idx = 32'(frame[1] - lspp_pkg::INDEX_BASE);
      spd = 32'({frame[3], frame[2]} >> 6);
      for (int s = 0; s < 4; s++) begin
        if (frame[5 + 4 * s][7] && tally < 32'(lspp_pkg::TALLY_MAX)) tally++;
      end
      for (int s = 0; s < 4; s++) begin
        lo      = frame[4 + 4 * s];
        hi      = frame[5 + 4 * s];
        bad     = hi[7];
        dist_mm = bad ? 32'd0 : 32'({hi[5:0], lo});
        inr     = !bad && dist_mm < MAX_RANGE_MM;
        rbin    = 0;
        if (inr) begin
          rbin = dist_mm * RANGE_BINS / MAX_RANGE_MM;
          if (rbin > 255) rbin = 255;
        end
        r.angle            = 9'(idx * 4 + s);
        r.distance_mm      = 14'(dist_mm);
        r.reading_invalid  = bad;
        r.range_bin        = 8'(rbin);
        r.in_range         = inr;
        r.rotation_speed   = 10'(spd);
        r.pass_done        = (idx == 32'(lspp_pkg::LAST_INDEX));
        r.pass_error_count = 9'(tally);
        r.last_of_packet   = (s == 3);
        readings_due.push_back(r);
      end
      if (idx == 32'(lspp_pkg::LAST_INDEX)) begin
        tally = 0;
        passes++;
      end
    endfunction

    function void cmp(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(logic [55:0] d, logic pdone, logic plast);
      reading_t e;
      if (readings_due.size() == 0) begin
        $error("result with nothing pending: angle %0d", d[8:0]);
        errors++;
        return;
      end
      e = readings_due.pop_front();
      checked++;
      cmp("angle",            32'(e.angle),            32'(d[8:0]));
      cmp("distance_mm",      32'(e.distance_mm),      32'(d[22:9]));
      cmp("reading_invalid",  32'(e.reading_invalid),  32'(d[23]));
      cmp("range_bin",        32'(e.range_bin),        32'(d[31:24]));
      cmp("in_range",         32'(e.in_range),         32'(d[32]));
      cmp("rotation_speed",   32'(e.rotation_speed),   32'(d[42:33]));
      cmp("pass_error_count", 32'(e.pass_error_count), 32'(d[51:43]));
      cmp("pass_done",        32'(e.pass_done),        32'(pdone));
      cmp("last_of_packet",   32'(e.last_of_packet),   32'(plast));
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [55:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  scan_scoreboard sb = new();
  int unsigned    cycles = 0;
  bit             idle_on = 1'b0;
  bit             hold_req = 1'b0;
  bit             rx_free = 1'b0;

  lidar_scan_packet_parser_unit #(
    .MAX_RANGE_MM(MAX_RANGE_MM),
    .RANGE_BINS(RANGE_BINS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d readings outstanding", cycles, sb.pending());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser, m_tlast);
  end

  // Sink: short random stalls, occasional long ones, and one long hold-off on request.
  initial begin
    int unsigned run_left;
    bit          ready_now;
    bit          held;
    run_left  = 0;
    ready_now = 1'b0;
    held      = 1'b0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        held     = 1'b1;
        run_left = 0;
      end else begin
        if (run_left == 0) begin
          ready_now = rx_free || ($urandom_range(0, 3) != 0);
          if (ready_now && $urandom_range(0, 5) == 0) run_left = $urandom_range(20, 60);
          else if ($urandom_range(0, 9) == 0) run_left = $urandom_range(12, 30);
          else run_left = $urandom_range(1, 3);
        end
        run_left--;
        m_tready <= ready_now;
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 31);
    if (r == 0) return $urandom_range(12, 30);
    if (r < 8) return $urandom_range(1, 3);
    return 0;
  endfunction

  // Hold the byte until it is taken; lower tvalid only when a gap follows.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_byte(b);
    gap = pick_gap();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Each reading word is {invalid, spare, distance[13:0]}, sent low byte first.
  task automatic send_frame(input logic [7:0] idx_byte, input logic [15:0] speed,
                            input logic [3:0][15:0] rd);
    send_byte(lspp_pkg::SYNC_BYTE);
    send_byte(idx_byte);
    send_byte(speed[7:0]);
    send_byte(speed[15:8]);
    for (int s = 0; s < 4; s++) begin
      send_byte(rd[s][7:0]);
      send_byte(rd[s][15:8]);
      send_byte(8'($urandom_range(0, 255)));
      send_byte(8'($urandom_range(0, 255)));
    end
    send_byte(8'($urandom_range(0, 255)));
    send_byte(8'($urandom_range(0, 255)));
  endtask

  function automatic logic [15:0] rand_reading();
    logic [13:0] dist_mm;
    case ($urandom_range(0, 7))
      0: return {1'b1, 15'($urandom_range(0, 32767))};
      1: return 16'($urandom_range(0, 65535));
      2: dist_mm = 14'($urandom_range(MAX_RANGE_MM - 10, MAX_RANGE_MM + 10));
      default: dist_mm = 14'($urandom_range(0, 4999));
    endcase
    return {1'b0, 1'($urandom_range(0, 1)), dist_mm};
  endfunction

  function automatic logic [7:0] rand_index_byte();
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r == 0) return lspp_pkg::INDEX_BASE + lspp_pkg::LAST_INDEX;
    if (r == 1) return ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 8'h9F))
                                                   : 8'($urandom_range(8'hFA, 8'hFF));
    return lspp_pkg::INDEX_BASE + 8'($urandom_range(0, 88));
  endfunction

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    logic [3:0][15:0] rd;
    logic [7:0]       b;
    int unsigned      frame_bytes, frames, kind, len;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Noise while hunting, then extremes of distance and speed.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hF9);
    rd = {16'h3FFF, 16'd4000, 16'd3999, 16'h0000};
    send_frame(lspp_pkg::INDEX_BASE, 16'h0000, rd);
    rd = {16'h7FFF, 16'h4001, 16'd1, 16'd15};
    send_frame(lspp_pkg::INDEX_BASE + 8'd1, 16'h003F, rd);
    // Index below and above the table; the first upper one is a sync byte inside a packet.
    send_frame(8'h9F, 16'h1234, rd);
    rd = {16'h00FA, 16'hFAFA, 16'h80FA, 16'h0FFA};
    send_frame(lspp_pkg::INDEX_BASE + lspp_pkg::INDEX_COUNT, 16'h5678, rd);
    send_frame(8'hFF, 16'h9ABC, rd);
    rd = {16'd2000, 16'hFFFF, 16'h8000, 16'hBFFF};
    send_frame(lspp_pkg::INDEX_BASE + 8'd88, 16'hFFFF, rd);
    send_frame(lspp_pkg::INDEX_BASE + lspp_pkg::LAST_INDEX, 16'h0040, rd);
    rd = {16'd0, 16'd100, 16'd1000, 16'd3000};
    send_frame(lspp_pkg::INDEX_BASE + lspp_pkg::LAST_INDEX, 16'hFFC0, rd);
    wait_drained();

    // Long sink hold-off while two good packets arrive back to back; the second stalls.
    hold_req = 1'b1;
    idle_on  = 1'b0;
    for (int k = 0; k < 2; k++) begin
      for (int s = 0; s < 4; s++) rd[s] = rand_reading();
      send_frame(lspp_pkg::INDEX_BASE + 8'(10 + k), 16'($urandom_range(0, 65535)), rd);
    end

    // Random traffic.
    frame_bytes = 0;
    frames      = 0;
    while (frame_bytes < 30) begin
      idle_on = ($urandom_range(0, 3) != 0);
      kind    = $urandom_range(0, 9);
      if (kind == 0) begin
        len = $urandom_range(1, 5);
        repeat (len) begin
          b = 8'($urandom_range(0, 255));
          if (b == lspp_pkg::SYNC_BYTE) b = b ^ 8'h01;
          send_byte(b);
        end
      end else if (kind == 1) begin
        // truncated packet: the bytes that follow complete it
        len = $urandom_range(1, 20);
        send_byte(lspp_pkg::SYNC_BYTE);
        repeat (len) send_byte(8'($urandom_range(0, 255)));
        frame_bytes += len + 1;
      end else if (kind == 2) begin
        send_byte(lspp_pkg::SYNC_BYTE);
        repeat (FRAME_LEN - 1) send_byte(8'($urandom_range(0, 255)));
        frame_bytes += FRAME_LEN;
      end else begin
        for (int s = 0; s < 4; s++) rd[s] = rand_reading();
        send_frame(rand_index_byte(), 16'($urandom_range(0, 65535)), rd);
        frame_bytes += FRAME_LEN;
      end
      frames++;
      if (frames == 2) wait_drained();
    end

    // Close a pass on a packet whose readings are all invalid.
    idle_on = 1'b0;
    rx_free = 1'b1;
    for (int s = 0; s < 4; s++) rd[s] = {1'b1, 15'($urandom_range(0, 32767))};
    send_frame(lspp_pkg::INDEX_BASE + lspp_pkg::LAST_INDEX, 16'($urandom_range(0, 65535)),
               rd);
    rx_free = 1'b0;
    s_tvalid <= 1'b0;

    wait_drained();
    repeat (20) @(posedge clk);
    $display("Sent %0d bytes: %0d good packets, %0d dropped, %0d passes closed.",
             sb.bytes_seen, sb.good_pkts, sb.dropped_pkts, sb.passes);
    $display("Checked %0d readings, %0d mismatches, including a long sink hold-off.",
             sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
